>>> rtl/motor_speed_ramp_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed ramp controller
// Clocked on clock and silenced while reset is high.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_RAMP_CONTROLLER_UNIT_MACROS_SVH
`define MOTOR_SPEED_RAMP_CONTROLLER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MSRC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MSRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/msrc_pkg.sv
// ----------------------------------------------------------------------------
// msrc_pkg
// Shared types and constants of the motor speed ramp controller.
// ----------------------------------------------------------------------------
package msrc_pkg;

   localparam logic [7:0]  DRIVE_MAX   = 8'd180;
   localparam logic [6:0]  PCT_MAX     = 7'd100;
   // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;
   localparam logic [1:0] CMD_KILL  = 2'd3;

   localparam logic [1:0] MODE_STOPPED  = 2'd0;
   localparam logic [1:0] MODE_STARTING = 2'd1;
   localparam logic [1:0] MODE_RUNNING  = 2'd2;
   localparam logic [1:0] MODE_STOPPING = 2'd3;

   localparam logic [1:0] CSR_STEP_SIZE  = 2'd0;
   localparam logic [1:0] CSR_STEP_DELAY = 2'd1;
   localparam logic [1:0] CSR_MIN_SPEED  = 2'd2;
   localparam logic [1:0] CSR_IDLE_SPEED = 2'd3;

   typedef struct packed {
      logic [7:0]  step_size;
      logic [15:0] step_delay_ms;
      logic [7:0]  min_speed;
      logic [7:0]  idle_speed;
   } cfg_type;

   // Registered command with the start product already formed
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  lo;
      logic [14:0] prod;
   } item_type;

endpackage

>>> rtl/motor_speed_ramp_controller_unit.sv
// A request passes through the input register and then the result register to its response.
// Throughput: one command per cycle unless the response stalls; the ramp state updates with the result.
// Reset (synchronous, active high): drive, setpoint and tick count cleared, mode stopped,
//   registers back to step size 1, step delay 10, min and idle speed 0.
// ----------------------------------------------------------------------------
// motor_speed_ramp_controller_unit
// Slew-rate limited motor drive with start, stop, kill and millisecond ticks.
// ----------------------------------------------------------------------------
`include "motor_speed_ramp_controller_unit_macros.svh"

module motor_speed_ramp_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [6:0]  req_speed_percent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_drive,
   output logic [1:0]  rsp_run_state,
   output logic        rsp_at_speed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import msrc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type item;
   logic     item_valid;
   logic     advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_SIZE:  cfg_in.step_size     = csr_wdata[7:0];
            CSR_STEP_DELAY: cfg_in.step_delay_ms = csr_wdata;
            CSR_MIN_SPEED:  cfg_in.min_speed     = csr_wdata[7:0];
            CSR_IDLE_SPEED: cfg_in.idle_speed    = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size     <= 8'd1;
         cfg_ff.step_delay_ms <= 16'd10;
         cfg_ff.min_speed     <= 8'd0;
         cfg_ff.idle_speed    <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msrc_intake u_intake (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_speed_percent (req_speed_percent),
      .cfg               (cfg_ff),
      .advance           (advance),
      .item_valid        (item_valid),
      .item              (item)
   );

   msrc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .item_valid    (item_valid),
      .item          (item),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive     (rsp_drive),
      .rsp_run_state (rsp_run_state),
      .rsp_at_speed  (rsp_at_speed)
   );

   `MSRC_ASSERT_SAME(a_drive_range, rsp_valid, rsp_drive <= DRIVE_MAX, "drive above full scale")
   `MSRC_ASSERT_SAME(a_no_overrun, item_valid && rsp_valid && rsp_stall, req_stall, "input taken over a full pipe")
   `MSRC_ASSERT_NEXT(a_kill_zero, advance && (item.cmd == CMD_KILL), (rsp_drive == 8'd0) && (rsp_run_state == MODE_STOPPED), "kill did not stop the drive")

endmodule

>>> rtl/msrc_intake.sv
// ----------------------------------------------------------------------------
// msrc_intake
// Input register: captures a command and forms percent times span for start.
// ----------------------------------------------------------------------------
module msrc_intake (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [6:0]         req_speed_percent,
   input  msrc_pkg::cfg_type  cfg,
   input  logic               advance,
   output logic               item_valid,
   output msrc_pkg::item_type item
);
   import msrc_pkg::*;

   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic       load;
   logic [6:0] pct_c;
   logic [7:0] lo, span;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !advance);

   always_comb begin
      pct_c        = (req_speed_percent > PCT_MAX) ? PCT_MAX : req_speed_percent;
      lo           = (cfg.min_speed > DRIVE_MAX) ? DRIVE_MAX : cfg.min_speed;
      span         = DRIVE_MAX - lo;
      item_in.cmd  = req_cmd;
      item_in.lo   = lo;
      item_in.prod = 15'({8'd0, pct_c} * {7'd0, span});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/msrc_core.sv
// ----------------------------------------------------------------------------
// msrc_core
// Ramp state update and result register.
// ----------------------------------------------------------------------------
module msrc_core (
   input  logic               clock,
   input  logic               reset,
   input  msrc_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  msrc_pkg::item_type item,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_drive,
   output logic [1:0]         rsp_run_state,
   output logic               rsp_at_speed
);
   import msrc_pkg::*;

   logic [7:0]  drive_ff, drive_in;
   logic [7:0]  target_ff, target_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_drive_ff;
   logic [1:0]  rsp_mode_ff;
   logic        rsp_at_ff, at_new;

   logic [7:0]  diff_old, diff_new;
   logic        at_old;
   logic [15:0] ticks_inc;
   logic [8:0]  sum_up;
   logic [27:0] quot_mul;
   logic [7:0]  quot;

   assign advance      = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      diff_old  = (target_ff >= drive_ff) ? target_ff - drive_ff : drive_ff - target_ff;
      at_old    = (diff_old == 8'd0) || (diff_old < cfg.step_size);
      ticks_inc = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
      sum_up    = {1'b0, drive_ff} + {1'b0, cfg.step_size};
      quot_mul  = {13'd0, item.prod} * {15'd0, RECIP_100};
      quot      = quot_mul[RECIP_SHIFT +: 8];

      drive_in  = drive_ff;
      target_in = target_ff;
      mode_in   = mode_ff;
      ticks_in  = ticks_ff;

      unique case (item.cmd)
         CMD_TICK: begin
            ticks_in = ticks_inc;
            if (at_old) begin
               mode_in = MODE_RUNNING;
            end else if (ticks_inc > cfg.step_delay_ms) begin
               ticks_in = 16'd0;
               if (target_ff > drive_ff) begin
                  drive_in = (sum_up > {1'b0, DRIVE_MAX}) ? DRIVE_MAX : sum_up[7:0];
                  mode_in  = MODE_STARTING;
               end else begin
                  drive_in = (drive_ff > cfg.step_size) ? drive_ff - cfg.step_size : 8'd0;
                  mode_in  = MODE_STOPPING;
               end
            end
            if (target_ff < cfg.step_size) begin
               mode_in = MODE_STOPPED;
            end
         end
         CMD_START: begin
            target_in = item.lo + quot;
            drive_in  = item.lo;
            mode_in   = MODE_STARTING;
         end
         CMD_STOP: begin
            target_in = (cfg.idle_speed > DRIVE_MAX) ? DRIVE_MAX : cfg.idle_speed;
         end
         CMD_KILL: begin
            drive_in  = 8'd0;
            target_in = 8'd0;
            mode_in   = MODE_STOPPED;
         end
         default: begin
            drive_in = drive_ff;
         end
      endcase

      diff_new = (target_in >= drive_in) ? target_in - drive_in : drive_in - target_in;
      at_new   = (diff_new == 8'd0) || (diff_new < cfg.step_size);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= 8'd0;
         target_ff    <= 8'd0;
         mode_ff      <= MODE_STOPPED;
         ticks_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            drive_ff  <= drive_in;
            target_ff <= target_in;
            mode_ff   <= mode_in;
            ticks_ff  <= ticks_in;
         end
      end
   end

   // hold the result while the far side stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff <= drive_in;
         rsp_mode_ff  <= mode_in;
         rsp_at_ff    <= at_new;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_run_state = rsp_mode_ff;
   assign rsp_at_speed  = rsp_at_ff;

endmodule
